@@ src/csc_pkg.sv @@
// Shared types and constants for the cycle stopwatch counter bank.
package csc_pkg;

  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 6;
  localparam int TS_W      = 64;
  localparam int CNT_W     = 32;
  localparam int SLOTS_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CSTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CSTOP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COPY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  typedef struct packed {
    logic             pend;
    logic [CNT_W-1:0] calls;
    logic [TS_W-1:0]  total;
    logic [TS_W-1:0]  last;
    logic [TS_W-1:0]  start;
  } slot_t;

endpackage

@@ src/csc_if.sv @@
// Valid/ready channel interfaces for command items and result items.
interface csc_in_if;
  import csc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] source_slot;
  logic [TS_W-1:0]   timestamp;
  modport source (output valid, command, slot, source_slot, timestamp, input ready);
  modport sink (input valid, command, slot, source_slot, timestamp, output ready);
endinterface

interface csc_out_if;
  import csc_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [TS_W-1:0]  last_cycles;
  logic [TS_W-1:0]  cycle_total;
  logic [CNT_W-1:0] calls_done;
  modport source (output valid, accepted, last_cycles, cycle_total, calls_done, input ready);
  modport sink (input valid, accepted, last_cycles, cycle_total, calls_done, output ready);
endinterface

@@ src/csc_mem.sv @@
// Slot store: one write port, two registered read ports.
module csc_mem #(
  parameter int DEPTH = csc_pkg::SLOTS_DEF,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  csc_pkg::slot_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   ra_addr,
  input  logic [AW-1:0]   rb_addr,
  output csc_pkg::slot_t  ra_data,
  output csc_pkg::slot_t  rb_data
);
  import csc_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
    end
  end

endmodule

@@ src/cycle_stopwatch_counter_bank.sv @@
// Top level of the cycle stopwatch counter bank.
// Each accepted item passes through decode, up to three passes through the
// shared 64-bit adder, and write back before its result is valid.
// The block takes no new item until the last one has left write back; stop
// takes the most adder passes, and a result held by the receiver keeps the
// block in write back. Reset: synchronous; a clearing pass zeroes the slot
// store, during which no item is accepted.
module cycle_stopwatch_counter_bank #(
  parameter int SLOTS = csc_pkg::SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  csc_in_if.sink   in_ch,
  csc_out_if.source out_ch
);
  import csc_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_ALU  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  localparam logic [1:0] ST_SUB  = 2'd0;
  localparam logic [1:0] ST_LAST = 2'd1;
  localparam logic [1:0] ST_TOT  = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r;
  logic [CMD_W-1:0] cmd_r;
  logic [AW-1:0]    addr_r;
  logic [TS_W-1:0]  ts_r;
  logic             s_ok_r, src_ok_r;
  slot_t            rda, rdb;
  slot_t            work_r;
  logic [TS_W-1:0]  acc_r;
  logic [1:0]       step_r, last_step_r;
  logic             ok_r, wr_r;
  logic             out_valid_r;

  logic             in_fire, out_free;
  logic [XW-1:0]    slot_x, src_x;
  logic [AW-1:0]    ra_addr, rb_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  slot_t            mem_wdata;

  slot_t            dec_w;
  logic             dec_ok, dec_wr, dec_steps;
  logic [1:0]       dec_first, dec_last;

  logic [TS_W-1:0]  op_a, op_b, sum;
  logic             op_c;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign slot_x  = XW'(in_ch.slot);
  assign src_x   = XW'(in_ch.source_slot);
  assign ra_addr = slot_x[AW-1:0];
  assign rb_addr = src_x[AW-1:0];

  assign mem_we    = (state_r == S_CLR) || (state_r == S_WB && out_free && wr_r);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : addr_r;
  assign mem_wdata = (state_r == S_CLR) ? '0 : work_r;

  csc_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_fire),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (rda),
    .rb_data (rdb)
  );

  // Command decode on the slot words just read.
  always_comb begin
    dec_w     = rda;
    dec_ok    = 1'b0;
    dec_wr    = 1'b0;
    dec_steps = 1'b0;
    dec_first = ST_SUB;
    dec_last  = ST_SUB;
    unique case (cmd_r)
      CMD_START: begin
        if (rda.pend) dec_w = '0;
        dec_w.last  = '0;
        dec_w.start = ts_r;
        dec_ok = 1'b1;
        dec_wr = 1'b1;
      end
      CMD_STOP: begin
        if (!rda.pend) begin
          dec_ok    = 1'b1;
          dec_wr    = 1'b1;
          dec_steps = 1'b1;
          dec_last  = ST_TOT;
        end
      end
      CMD_CSTART: begin
        if (!rda.pend) begin
          dec_w.start = ts_r;
          dec_ok = 1'b1;
          dec_wr = 1'b1;
        end
      end
      CMD_CSTOP: begin
        if (!rda.pend) begin
          dec_ok    = 1'b1;
          dec_wr    = 1'b1;
          dec_steps = 1'b1;
          dec_last  = ST_LAST;
        end
      end
      CMD_COPY: begin
        if (src_ok_r && !rdb.pend) begin
          if (rda.pend) dec_w = '0;
          dec_w.last = rdb.last;
          dec_ok    = 1'b1;
          dec_wr    = 1'b1;
          dec_steps = 1'b1;
          dec_first = ST_TOT;
          dec_last  = ST_TOT;
        end
      end
      CMD_READ: begin
        dec_ok = 1'b1;
      end
      CMD_CLEAR: begin
        dec_w.pend = 1'b1;
        dec_ok = 1'b1;
        dec_wr = 1'b1;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
    if (!s_ok_r) begin
      dec_ok    = 1'b0;
      dec_wr    = 1'b0;
      dec_steps = 1'b0;
    end
  end

  // Shared 64-bit adder.
  always_comb begin
    case (step_r)
      ST_SUB: begin
        op_a = ts_r;
        op_b = ~work_r.start;
        op_c = 1'b1;
      end
      ST_LAST: begin
        op_a = work_r.last;
        op_b = acc_r;
        op_c = 1'b0;
      end
      default: begin
        op_a = work_r.total;
        op_b = work_r.last;
        op_c = 1'b0;
      end
    endcase
    sum = op_a + op_b + TS_W'(op_c);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_cnt_r == AW'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_DEC;
      S_DEC:  state_nxt = dec_steps ? S_ALU : S_WB;
      S_ALU:  if (step_r == last_step_r) state_nxt = S_WB;
      S_WB:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_WB && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_ch.command;
      addr_r   <= ra_addr;
      ts_r     <= in_ch.timestamp;
      s_ok_r   <= ({{(32-SLOT_W){1'b0}}, in_ch.slot} < 32'(SLOTS));
      src_ok_r <= ({{(32-SLOT_W){1'b0}}, in_ch.source_slot} < 32'(SLOTS));
    end
    if (state_r == S_DEC) begin
      work_r      <= dec_w;
      ok_r        <= dec_ok;
      wr_r        <= dec_wr;
      step_r      <= dec_first;
      last_step_r <= dec_last;
    end
    if (state_r == S_ALU) begin
      step_r <= step_r + 2'd1;
      case (step_r)
        ST_SUB:  acc_r <= sum;
        ST_LAST: work_r.last <= sum;
        default: begin
          work_r.total <= sum;
          work_r.calls <= work_r.calls + CNT_W'(1);
        end
      endcase
    end
    if (state_r == S_WB && out_free) begin
      out_ch.accepted    <= ok_r;
      out_ch.last_cycles <= s_ok_r ? work_r.last : '0;
      out_ch.cycle_total <= s_ok_r ? work_r.total : '0;
      out_ch.calls_done  <= s_ok_r ? work_r.calls : '0;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  a_write_only_wb_clr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_WB || state_r == S_CLR))
    else $error("slot store written outside write back");

  a_accept_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DEC))
    else $error("accepted item not decoded");

  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_WB))
    else $error("result raised outside write back");
`endif

endmodule

@@ tb/cycle_stopwatch_counter_bank_test.sv @@
// Testbench for the cycle stopwatch counter bank: directed and random commands, scoreboarded.
module cycle_stopwatch_counter_bank_test;
  import csc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;
  localparam int HOT_SLOTS = 8;

  typedef struct packed {
    logic             accepted;
    logic [TS_W-1:0]  last;
    logic [TS_W-1:0]  total;
    logic [CNT_W-1:0] count;
  } tally_t;

  logic clk;
  logic rst_n;

  csc_in_if  in_ch();
  csc_out_if out_ch();

  cycle_stopwatch_counter_bank dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [TS_W-1:0]  sw_start [SLOTS_DEF];
  logic [TS_W-1:0]  sw_last  [SLOTS_DEF];
  logic [TS_W-1:0]  sw_total [SLOTS_DEF];
  logic [CNT_W-1:0] sw_calls [SLOTS_DEF];
  logic             sw_pend  [SLOTS_DEF];

  tally_t          pending_tallies[$];
  tally_t          want;
  int              errors = 0;
  int              items_sent = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_left = 0;
  logic [TS_W-1:0] now_ts = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL cycle_stopwatch_counter_bank");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        $error("result item with no command outstanding");
        errors++;
      end else begin
        want = pending_tallies.pop_front();
        if (out_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_ch.accepted);
          errors++;
        end
        if (out_ch.last_cycles !== want.last) begin
          $error("last_cycles: expected %0h, got %0h", want.last, out_ch.last_cycles);
          errors++;
        end
        if (out_ch.cycle_total !== want.total) begin
          $error("cycle_total: expected %0h, got %0h", want.total, out_ch.cycle_total);
          errors++;
        end
        if (out_ch.calls_done !== want.count) begin
          $error("calls_done: expected %0d, got %0d", want.count, out_ch.calls_done);
          errors++;
        end
      end
    end
  end

  function automatic void zero_slot(input logic [SLOT_W-1:0] s);
    sw_start[s] = '0;
    sw_last[s]  = '0;
    sw_total[s] = '0;
    sw_calls[s] = '0;
    sw_pend[s]  = 1'b0;
  endfunction

  function automatic tally_t stopwatch_update(input logic [CMD_W-1:0] cmd,
                                              input logic [SLOT_W-1:0] s,
                                              input logic [SLOT_W-1:0] src,
                                              input logic [TS_W-1:0] ts);
    tally_t          t;
    logic [TS_W-1:0] v;
    t.accepted = 1'b0;
    case (cmd)
      CMD_START: begin
        if (sw_pend[s]) zero_slot(s);
        sw_last[s]  = '0;
        sw_start[s] = ts;
        t.accepted  = 1'b1;
      end
      CMD_STOP: begin
        if (!sw_pend[s]) begin
          sw_last[s]  = sw_last[s] + (ts - sw_start[s]);
          sw_total[s] = sw_total[s] + sw_last[s];
          sw_calls[s] = sw_calls[s] + 1'b1;
          t.accepted  = 1'b1;
        end
      end
      CMD_CSTART: begin
        if (!sw_pend[s]) begin
          sw_start[s] = ts;
          t.accepted  = 1'b1;
        end
      end
      CMD_CSTOP: begin
        if (!sw_pend[s]) begin
          sw_last[s] = sw_last[s] + (ts - sw_start[s]);
          t.accepted = 1'b1;
        end
      end
      CMD_COPY: begin
        if (!sw_pend[src]) begin
          v = sw_last[src];
          if (sw_pend[s]) zero_slot(s);
          sw_last[s]  = v;
          sw_total[s] = sw_total[s] + v;
          sw_calls[s] = sw_calls[s] + 1'b1;
          t.accepted  = 1'b1;
        end
      end
      CMD_READ: t.accepted = 1'b1;
      CMD_CLEAR: begin
        sw_pend[s] = 1'b1;
        t.accepted = 1'b1;
      end
      default: t.accepted = 1'b0;
    endcase
    t.last  = sw_last[s];
    t.total = sw_total[s];
    t.count = sw_calls[s];
    return t;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s,
                          input logic [SLOT_W-1:0] src, input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.slot        <= s;
    in_ch.source_slot <= src;
    in_ch.timestamp   <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_tallies.push_back(stopwatch_update(cmd, s, src, ts));
    items_sent++;
  endtask

  function automatic void advance_stamp();
    if ($urandom_range(49) == 0) now_ts = {$urandom, $urandom};
    else now_ts = now_ts + TS_W'($urandom_range(1, 3000));
  endfunction

  function automatic logic [TS_W-1:0] any_stamp();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return now_ts;
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(99) < 75) return SLOT_W'($urandom_range(HOT_SLOTS - 1));
    return SLOT_W'($urandom_range(SLOTS_DEF - 1));
  endfunction

  function automatic logic [SLOT_W-1:0] any_slot();
    return SLOT_W'($urandom_range(63));
  endfunction

  task automatic run_timing_sequence(input logic [SLOT_W-1:0] s);
    int laps;
    laps = $urandom_range(0, 2);
    advance_stamp();
    send_cmd(CMD_START, s, any_slot(), now_ts);
    repeat (laps) begin
      advance_stamp();
      send_cmd(CMD_CSTOP, s, any_slot(), now_ts);
      advance_stamp();
      send_cmd(CMD_CSTART, s, any_slot(), now_ts);
    end
    advance_stamp();
    send_cmd(CMD_STOP, s, any_slot(), now_ts);
    if ($urandom_range(99) < 30) send_cmd(CMD_COPY, pick_slot(), s, any_stamp());
    if ($urandom_range(99) < 20) send_cmd(CMD_READ, s, any_slot(), any_stamp());
  endtask

  task automatic send_noise();
    send_cmd(CMD_W'($urandom_range(7)), pick_slot(), pick_slot(), any_stamp());
  endtask

  task automatic test_reset_state();
    send_cmd(CMD_READ, 6'd0, 6'd63, '0);
    send_cmd(CMD_READ, 6'd63, 6'd0, '1);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_cmd(CMD_START, 6'd0, 6'd0, '0);
    send_cmd(CMD_STOP, 6'd0, 6'd63, '1);
    // elapsed time wraps through zero
    send_cmd(CMD_START, 6'd63, 6'd0, '1);
    send_cmd(CMD_CSTOP, 6'd63, 6'd0, 64'd4);
    send_cmd(CMD_CSTART, 6'd63, 6'd0, 64'd10);
    send_cmd(CMD_CSTOP, 6'd63, 6'd0, 64'd20);
    send_cmd(CMD_STOP, 6'd63, 6'd0, 64'd30);
    send_cmd(CMD_COPY, 6'd1, 6'd63, '0);
    send_cmd(CMD_COPY, 6'd1, 6'd1, '0);
    // commands refused while a clear is pending, apart from read
    send_cmd(CMD_CLEAR, 6'd63, 6'd0, '0);
    send_cmd(CMD_STOP, 6'd63, 6'd0, 64'd100);
    send_cmd(CMD_CSTART, 6'd63, 6'd0, 64'd100);
    send_cmd(CMD_CSTOP, 6'd63, 6'd0, 64'd200);
    send_cmd(CMD_READ, 6'd63, 6'd0, '0);
    send_cmd(CMD_COPY, 6'd2, 6'd63, '0);
    // pending destination is zeroed by copy
    send_cmd(CMD_CLEAR, 6'd1, 6'd0, '0);
    send_cmd(CMD_COPY, 6'd1, 6'd0, '0);
    send_cmd(CMD_START, 6'd63, 6'd0, 64'h5555_5555_5555_5555);
    send_cmd(CMD_UNDEF, 6'd0, 6'd63, '1);
    send_cmd(CMD_CLEAR, 6'd0, 6'd0, '0);
    send_cmd(CMD_CLEAR, 6'd0, 6'd0, '0);
    send_cmd(CMD_START, 6'd0, 6'd42, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(CMD_STOP, 6'd0, 6'd21, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    repeat (40) send_noise();
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    int first;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    first = items_sent;
    while (items_sent - first < n) begin
      if ($urandom_range(99) < 70) run_timing_sequence(pick_slot());
      else send_noise();
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < SLOTS_DEF; i++) zero_slot(SLOT_W'(i));
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_READ;
    in_ch.slot        <= '0;
    in_ch.source_slot <= '0;
    in_ch.timestamp   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_backpressure();
    test_random(300, 29, 58);
    test_random(300, 58, 29);
    test_random(290, 0, 0);
    in_ch.valid <= 1'b0;

    guard = 0;
    while (pending_tallies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_tallies.size() != 0) begin
      $error("%0d results never arrived", pending_tallies.size());
      errors++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS cycle_stopwatch_counter_bank");
    end else begin
      $display("FAIL cycle_stopwatch_counter_bank");
    end
    $finish;
  end

endmodule
